@@ sv/mkd_pkg.sv @@
// Shared types, codes and constants of the Morse key decoder.
// Holds the Morse tree lookup. Depends on nothing.
package mkd_pkg;

	// Tree geometry: dot goes to 2i+1, dash to 2i+2
	localparam int TREE_LEVELS = 6;
	localparam int TREE_IDX_W  = TREE_LEVELS;
	localparam int DEPTH_W     = 3;

	// Configuration port
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_DOT_LIMIT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LETTER_GAP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WORD_GAP   = 2'd2;

	localparam int TIMER_WIDTH_DEF = 16;
	localparam int DOT_LIMIT_RST   = 25;
	localparam int LETTER_GAP_RST  = 100;
	localparam int WORD_GAP_RST    = 200;

	// Result queue
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = OUT_PTR_W + 1;

	// Stream widths
	localparam int S_DATA_W = 8;
	localparam int M_DATA_W = 16;

	// Key event codes
	localparam logic [1:0] KEY_NONE    = 2'd0;
	localparam logic [1:0] KEY_PRESS   = 2'd1;
	localparam logic [1:0] KEY_RELEASE = 2'd2;

	localparam logic [6:0] CHAR_NONE  = 7'h00;
	localparam logic [6:0] CHAR_BLANK = 7'h5F;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_ELEMENT = 3'd1,
		EV_LETTER  = 3'd2,
		EV_WORD    = 3'd3,
		EV_ERROR   = 3'd4
	} ev_kind_t;

	// One tick's keying decision, handed from keyer to tree walk
	typedef struct packed {
		logic elem;    // element finished on release
		logic dash;    // that element is a dash
		logic letter;  // letter gap ran out
		logic word;    // word gap ran out
	} key_act_t;

	// Result item, kind in the low bits
	typedef struct packed {
		logic [6:0] character;
		ev_kind_t   event_kind;
	} result_t;

	// Morse tree in heap order, ASCII of each node
	function automatic logic [6:0] node_char(input logic [TREE_IDX_W-1:0] idx);
		logic [6:0] c;
		unique case (idx)
			6'd1:  c = 7'h45; // E
			6'd2:  c = 7'h54; // T
			6'd3:  c = 7'h49; // I
			6'd4:  c = 7'h41; // A
			6'd5:  c = 7'h4E; // N
			6'd6:  c = 7'h4D; // M
			6'd7:  c = 7'h53; // S
			6'd8:  c = 7'h55; // U
			6'd9:  c = 7'h52; // R
			6'd10: c = 7'h57; // W
			6'd11: c = 7'h44; // D
			6'd12: c = 7'h4B; // K
			6'd13: c = 7'h47; // G
			6'd14: c = 7'h4F; // O
			6'd15: c = 7'h48; // H
			6'd16: c = 7'h56; // V
			6'd17: c = 7'h46; // F
			6'd19: c = 7'h4C; // L
			6'd21: c = 7'h50; // P
			6'd22: c = 7'h4A; // J
			6'd23: c = 7'h42; // B
			6'd24: c = 7'h58; // X
			6'd25: c = 7'h43; // C
			6'd26: c = 7'h59; // Y
			6'd27: c = 7'h5A; // Z
			6'd28: c = 7'h51; // Q
			6'd31: c = 7'h35; // 5
			6'd32: c = 7'h34; // 4
			6'd34: c = 7'h33; // 3
			6'd38: c = 7'h32; // 2
			6'd46: c = 7'h31; // 1
			6'd47: c = 7'h36; // 6
			6'd55: c = 7'h37; // 7
			6'd59: c = 7'h38; // 8
			6'd61: c = 7'h39; // 9
			6'd62: c = 7'h30; // 0
			6'd63: c = CHAR_NONE;  // outside the tree
			default: c = CHAR_BLANK;
		endcase
		return c;
	endfunction

endpackage

@@ sv/mkd_keyer.sv @@
// Keying state machine with the dot, letter and word countdown timers.
// Also holds the three timing registers. Depends on mkd_pkg.
module mkd_keyer
	import mkd_pkg::*;
#(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 tick,
	input  logic [1:0]           key_event,
	input  logic                 at_leaf,
	output key_act_t             act
);

	typedef enum logic [4:0] {
		PH_IDLE       = 5'b00001,
		PH_LETTER_GAP = 5'b00010,
		PH_ELEM_GAP   = 5'b00100,
		PH_DOT        = 5'b01000,
		PH_DASH       = 5'b10000
	} phase_t;

	localparam logic [TIMER_WIDTH-1:0] ONE = TIMER_WIDTH'(1);

	phase_t                 phase_q, phase_d;
	logic [TIMER_WIDTH-1:0] dot_limit_q, letter_gap_q, word_gap_q;
	logic [TIMER_WIDTH-1:0] dot_q, letter_q, word_q;
	logic [TIMER_WIDTH-1:0] dot_d, letter_d, word_d;
	logic [TIMER_WIDTH-1:0] dot_dec, letter_dec, word_dec;
	logic [TIMER_WIDTH-1:0] cfg_v;
	logic                   press, release_k;

	generate
		if (TIMER_WIDTH <= CFG_W) begin : g_narrow
			assign cfg_v = cfg_data[TIMER_WIDTH-1:0];
		end else begin : g_wide
			assign cfg_v = {{(TIMER_WIDTH-CFG_W){1'b0}}, cfg_data};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_limit_q  <= TIMER_WIDTH'(DOT_LIMIT_RST);
			letter_gap_q <= TIMER_WIDTH'(LETTER_GAP_RST);
			word_gap_q   <= TIMER_WIDTH'(WORD_GAP_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DOT_LIMIT:  dot_limit_q  <= cfg_v;
				CFG_LETTER_GAP: letter_gap_q <= cfg_v;
				CFG_WORD_GAP:   word_gap_q   <= cfg_v;
				default: ;
			endcase
		end
	end

	assign press      = (key_event == KEY_PRESS);
	assign release_k  = (key_event == KEY_RELEASE);
	assign dot_dec    = dot_q - ONE;
	assign letter_dec = letter_q - ONE;
	assign word_dec   = word_q - ONE;

	always_comb begin
		phase_d  = phase_q;
		dot_d    = dot_dec;
		letter_d = letter_dec;
		word_d   = word_dec;
		act      = '0;
		unique case (phase_q)
			PH_IDLE, PH_LETTER_GAP, PH_ELEM_GAP: begin
				// press beats any timeout in the same tick
				priority if (press) begin
					phase_d = PH_DOT;
					dot_d   = dot_limit_q;
				end else if (phase_q == PH_ELEM_GAP && letter_dec == '0) begin
					act.letter = 1'b1;
					phase_d    = PH_LETTER_GAP;
				end else if (phase_q == PH_LETTER_GAP && word_dec == '0) begin
					act.word = 1'b1;
					phase_d  = PH_IDLE;
				end else begin
				end
			end
			PH_DOT, PH_DASH: begin
				priority if (release_k) begin
					act.elem = 1'b1;
					act.dash = (phase_q == PH_DASH);
					if (at_leaf) begin
						phase_d = PH_IDLE;
					end else begin
						phase_d  = PH_ELEM_GAP;
						letter_d = letter_gap_q;
						word_d   = word_gap_q;
					end
				end else if (phase_q == PH_DOT && dot_dec == '0) begin
					phase_d = PH_DASH;
				end else begin
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			dot_q    <= TIMER_WIDTH'(DOT_LIMIT_RST);
			letter_q <= TIMER_WIDTH'(LETTER_GAP_RST);
			word_q   <= TIMER_WIDTH'(WORD_GAP_RST);
		end else if (tick) begin
			phase_q  <= phase_d;
			dot_q    <= dot_d;
			letter_q <= letter_d;
			word_q   <= word_d;
		end
	end

endmodule

@@ sv/mkd_walk.sv @@
// Morse tree walk: position and depth in the tree, builds the result item.
// Depends on mkd_pkg.
module mkd_walk
	import mkd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     tick,
	input  key_act_t act,
	output logic     at_leaf,
	output result_t  res
);

	logic [TREE_IDX_W-1:0] idx_q, idx_d, idx_step;
	logic [DEPTH_W-1:0]    depth_q, depth_d;

	assign at_leaf  = (depth_q >= DEPTH_W'(TREE_LEVELS - 1));
	assign idx_step = {idx_q[TREE_IDX_W-2:0], 1'b0} + (act.dash ? 6'd2 : 6'd1);

	always_comb begin
		idx_d          = idx_q;
		depth_d        = depth_q;
		res.event_kind = EV_NONE;
		res.character  = CHAR_NONE;
		priority if (act.elem && at_leaf) begin
			res.event_kind = EV_ERROR;
			idx_d          = '0;
			depth_d        = '0;
		end else if (act.elem) begin
			idx_d          = idx_step;
			depth_d        = depth_q + DEPTH_W'(1);
			res.event_kind = EV_ELEMENT;
			res.character  = node_char(idx_step);
		end else if (act.letter || act.word) begin
			res.event_kind = act.letter ? EV_LETTER : EV_WORD;
			res.character  = node_char(idx_q);
			idx_d          = '0;
			depth_d        = '0;
		end else begin
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			depth_q <= '0;
		end else if (tick) begin
			idx_q   <= idx_d;
			depth_q <= depth_d;
		end
	end

endmodule

@@ sv/mkd_out_fifo.sv @@
// Small result queue that decouples the tick pipeline from the output side.
// Depends on mkd_pkg.
module mkd_out_fifo
	import mkd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  result_t              push_data,
	input  logic                 pop,
	output logic                 valid,
	output result_t              head,
	output logic [OUT_CNT_W-1:0] count
);

	result_t              mem [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [OUT_CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
			unique case ({push, pop})
				2'b10:   count_q <= count_q + OUT_CNT_W'(1);
				2'b01:   count_q <= count_q - OUT_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign valid = (count_q != '0);
	assign head  = mem[rd_ptr_q];
	assign count = count_q;

endmodule

@@ sv/morse_key_decoder.sv @@
// Morse key decoder top level: input stage, keyer, tree walk, result queue.
// Depends on mkd_pkg, mkd_keyer, mkd_walk, mkd_out_fifo.
//
// Each input item is one tick carrying a key event (none, press, release);
// each tick yields exactly one result item: an event kind (none, element,
// letter, word gap, error) and the ASCII of the current Morse tree node
// ('_' where the node has no letter, 0 on error or none). A press held no
// longer than dot_limit ticks is a dot, longer is a dash; after a release,
// letter_gap idle ticks end the letter and word_gap idle ticks end the word.
// The block takes one item per clock while s_tready is high. The item is
// registered, then keyer and tree walk update their state in one short pass
// and the result lands in a four-entry output queue. s_tready is computed
// from that queue's fill plus the item in flight, so it never depends
// combinationally on m_tready; a stalled output stops intake only once
// queued results plus the item in flight reach four. Timing registers are
// written through cfg_we/cfg_index/cfg_data and take effect at the next
// reload of the matching timer; write them only while the block is idle.
module morse_key_decoder
	import mkd_pkg::*;
#(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// key ticks in
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_DATA_W-1:0]  s_tdata,   // [1:0] key_event, rest zero
	// decoded results out
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_DATA_W-1:0]  m_tdata    // [2:0] event_kind, [9:3] character
);

	logic                 valid_s1;
	logic [1:0]           key_s1;
	logic                 accept;
	key_act_t             act;
	logic                 at_leaf;
	result_t              res;
	result_t              head;
	logic [OUT_CNT_W-1:0] fifo_count;
	logic [OUT_CNT_W:0]   pending;

	// item in flight counts against queue space
	assign pending  = {1'b0, fifo_count} + {{OUT_CNT_W{1'b0}}, valid_s1};
	assign s_tready = (pending < (OUT_CNT_W+1)'(OUT_DEPTH));
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_s1 <= s_tdata[1:0];
		end
	end

	mkd_keyer #(
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_keyer (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tick      (valid_s1),
		.key_event (key_s1),
		.at_leaf   (at_leaf),
		.act       (act)
	);

	mkd_walk u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (valid_s1),
		.act     (act),
		.at_leaf (at_leaf),
		.res     (res)
	);

	mkd_out_fifo u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_data (res),
		.pop       (m_tvalid && m_tready),
		.valid     (m_tvalid),
		.head      (head),
		.count     (fifo_count)
	);

	assign m_tdata = {{(M_DATA_W - $bits(result_t)){1'b0}}, head};

endmodule

@@ sv/mkd_checker.sv @@
// Port-level checks on the Morse key decoder, bound to the top level.
// Depends on mkd_pkg and morse_key_decoder.
module mkd_checker
	import mkd_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata
);

	logic [2:0] kind;
	logic [6:0] chr;

	assign kind = m_tdata[2:0];
	assign chr  = m_tdata[9:3];

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (kind <= EV_ERROR && m_tdata[15:10] == '0))
		else $error("bad event kind or padding");

	// error and none carry no character
	a_err_char: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (kind == EV_ERROR || kind == EV_NONE) |-> chr == CHAR_NONE)
		else $error("character on error or none");

	// a word gap always follows a letter, so the walk is at the root
	a_word_char: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && kind == EV_WORD |-> chr == CHAR_BLANK)
		else $error("word gap not at root");

	// an accepted item is registered, then its result is queued and shows on m_tvalid
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##2 m_tvalid)
		else $error("accepted item produced no result");

endmodule

bind morse_key_decoder mkd_checker u_mkd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ tb/tb_top.sv @@
// Self-checking bench for morse_key_decoder: key ticks in, decoded events out.
// Directed table first, then random keying phases; depends on mkd_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_top
	import mkd_pkg::*;
();

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;

	// key event that is neither press nor release
	localparam logic [1:0] KEY_NOISE = 2'd3;

	// Morse tree, preorder walk, dot branch first
	localparam logic [8*63-1:0] TREE_PREORDER = {
		"_EISH54V_3UF____",
		"2ARL_____WP__J_1",
		"TNDB6_X__KC__Y__",
		"MGZ7_Q__O_8__90"
	};

	typedef enum logic [2:0] {
		KP_IDLE,
		KP_LETTER_GAP,
		KP_ELEM_GAP,
		KP_DOT,
		KP_DASH
	} keyer_phase_t;

	typedef struct packed {
		ev_kind_t   kind;
		logic [6:0] ch;
	} tick_result_t;

	typedef enum logic {
		ROW_TICK,
		ROW_CFG
	} row_op_t;

	// code is the key event for a tick row, the register index for a config row
	typedef struct packed {
		row_op_t    op;
		logic [1:0] code;
		logic [15:0] val;
		logic       typed;
		ev_kind_t   kind;
		logic [6:0] ch;
	} dir_row_t;

	// Directed part. Rows with typed = 1 carry the result outright; the rest
	// are checked against the decoder model below.
	localparam dir_row_t DIRECTED [27] = '{
		// reset timings 25/100/200
		'{ROW_TICK, KEY_NONE,       16'd0, 1'b1, EV_NONE,    CHAR_NONE},
		'{ROW_TICK, KEY_PRESS,      16'd0, 1'b1, EV_NONE,    CHAR_NONE},
		'{ROW_TICK, KEY_RELEASE,    16'd0, 1'b1, EV_ELEMENT, 7'h45},     // dot: E
		'{ROW_TICK, KEY_RELEASE,    16'd0, 1'b0, EV_NONE,    CHAR_NONE}, // stray release
		'{ROW_TICK, KEY_NOISE,      16'd0, 1'b0, EV_NONE,    CHAR_NONE},
		// short timings
		'{ROW_CFG,  CFG_DOT_LIMIT,  16'd1, 1'b0, EV_NONE,    CHAR_NONE},
		'{ROW_CFG,  CFG_LETTER_GAP, 16'd2, 1'b0, EV_NONE,    CHAR_NONE},
		'{ROW_CFG,  CFG_WORD_GAP,   16'd3, 1'b0, EV_NONE,    CHAR_NONE},
		'{ROW_TICK, KEY_PRESS,      16'd0, 1'b0, EV_NONE,    CHAR_NONE},
		'{ROW_TICK, KEY_PRESS,      16'd0, 1'b0, EV_NONE,    CHAR_NONE}, // press while held
		'{ROW_TICK, KEY_RELEASE,    16'd0, 1'b0, EV_NONE,    CHAR_NONE}, // dash
		'{ROW_TICK, KEY_NONE,       16'd0, 1'b0, EV_NONE,    CHAR_NONE},
		'{ROW_TICK, KEY_NONE,       16'd0, 1'b0, EV_NONE,    CHAR_NONE}, // letter ends
		'{ROW_TICK, KEY_NONE,       16'd0, 1'b0, EV_NONE,    CHAR_NONE}, // word ends
		'{ROW_TICK, KEY_PRESS,      16'd0, 1'b0, EV_NONE,    CHAR_NONE},
		'{ROW_TICK, KEY_RELEASE,    16'd0, 1'b0, EV_NONE,    CHAR_NONE}, // release beats dot timeout
		'{ROW_TICK, KEY_NONE,       16'd0, 1'b0, EV_NONE,    CHAR_NONE},
		'{ROW_TICK, KEY_PRESS,      16'd0, 1'b0, EV_NONE,    CHAR_NONE}, // press beats letter timeout
		'{ROW_TICK, KEY_RELEASE,    16'd0, 1'b0, EV_NONE,    CHAR_NONE},
		'{ROW_TICK, KEY_PRESS,      16'd0, 1'b0, EV_NONE,    CHAR_NONE},
		'{ROW_TICK, KEY_RELEASE,    16'd0, 1'b0, EV_NONE,    CHAR_NONE},
		'{ROW_TICK, KEY_PRESS,      16'd0, 1'b0, EV_NONE,    CHAR_NONE},
		'{ROW_TICK, KEY_RELEASE,    16'd0, 1'b0, EV_NONE,    CHAR_NONE},
		'{ROW_TICK, KEY_PRESS,      16'd0, 1'b0, EV_NONE,    CHAR_NONE},
		'{ROW_TICK, KEY_RELEASE,    16'd0, 1'b0, EV_NONE,    CHAR_NONE}, // deepest leaf
		'{ROW_TICK, KEY_PRESS,      16'd0, 1'b0, EV_NONE,    CHAR_NONE},
		'{ROW_TICK, KEY_RELEASE,    16'd0, 1'b1, EV_ERROR,   CHAR_NONE}  // below the leaves
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata;   // [1:0] key_event, rest zero
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_DATA_W-1:0]  m_tdata;   // [2:0] event_kind, [9:3] character

	// decoder model state
	logic [6:0]   morse_char [64];
	logic [15:0]  cfg_dot_limit, cfg_letter_gap, cfg_word_gap;
	keyer_phase_t key_phase;
	logic [15:0]  dot_cnt, letter_cnt, word_cnt;
	logic [5:0]   node_idx;
	logic [2:0]   node_depth;

	tick_result_t pending[$];
	tick_result_t want;
	int           errors;
	int           tick_count;
	int           src_idle_pct;
	int           sink_stall_pct;
	int           cycle_count;

	morse_key_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int imin(input int a, input int b);
		return (a < b) ? a : b;
	endfunction

	// Tree in heap order from the preorder string; explicit stack, dot child on top
	task automatic reset_decoder_model();
		int stk[64];
		int sp;
		int pos;
		int h;
		for (int i = 0; i < 64; i++)
			morse_char[i] = CHAR_NONE;
		stk[0] = 0;
		sp = 1;
		pos = 0;
		while (sp > 0) begin
			sp--;
			h = stk[sp];
			morse_char[h] = TREE_PREORDER[8*(62-pos) +: 7];
			pos++;
			if (2*h + 2 < 63) begin
				stk[sp] = 2*h + 2;
				sp++;
			end
			if (2*h + 1 < 63) begin
				stk[sp] = 2*h + 1;
				sp++;
			end
		end
		cfg_dot_limit  = 16'(DOT_LIMIT_RST);
		cfg_letter_gap = 16'(LETTER_GAP_RST);
		cfg_word_gap   = 16'(WORD_GAP_RST);
		key_phase  = KP_IDLE;
		dot_cnt    = cfg_dot_limit;
		letter_cnt = cfg_letter_gap;
		word_cnt   = cfg_word_gap;
		node_idx   = '0;
		node_depth = '0;
	endtask

	// One tick of the keyer and tree walk
	task automatic decode_tick(input logic [1:0] key, output tick_result_t r);
		logic press;
		logic release_k;
		press     = (key == KEY_PRESS);
		release_k = (key == KEY_RELEASE);
		r.kind = EV_NONE;
		r.ch   = CHAR_NONE;
		// all timers count down every tick and wrap
		dot_cnt    = dot_cnt - 16'd1;
		letter_cnt = letter_cnt - 16'd1;
		word_cnt   = word_cnt - 16'd1;
		case (key_phase)
			KP_IDLE, KP_LETTER_GAP, KP_ELEM_GAP: begin
				if (press) begin
					// a press wins over any gap timeout in the same tick
					key_phase = KP_DOT;
					dot_cnt   = cfg_dot_limit;
				end else if (key_phase == KP_ELEM_GAP && letter_cnt == 16'd0) begin
					r.kind     = EV_LETTER;
					r.ch       = morse_char[node_idx];
					node_idx   = '0;
					node_depth = '0;
					key_phase  = KP_LETTER_GAP;
				end else if (key_phase == KP_LETTER_GAP && word_cnt == 16'd0) begin
					r.kind     = EV_WORD;
					r.ch       = morse_char[node_idx];
					node_idx   = '0;
					node_depth = '0;
					key_phase  = KP_IDLE;
				end
			end
			KP_DOT, KP_DASH: begin
				if (release_k) begin
					if (node_depth >= 3'(TREE_LEVELS - 1)) begin
						r.kind     = EV_ERROR;
						node_idx   = '0;
						node_depth = '0;
						key_phase  = KP_IDLE;
					end else begin
						node_idx   = 6'({node_idx, 1'b0} + ((key_phase == KP_DOT) ? 1 : 2));
						node_depth = node_depth + 3'd1;
						r.kind     = EV_ELEMENT;
						r.ch       = morse_char[node_idx];
						key_phase  = KP_ELEM_GAP;
						letter_cnt = cfg_letter_gap;
						word_cnt   = cfg_word_gap;
					end
				end else if (key_phase == KP_DOT && dot_cnt == 16'd0) begin
					key_phase = KP_DASH;
				end
			end
			default: key_phase = KP_IDLE;
		endcase
	endtask

	// Offer one tick, hold it until accepted, then log what it should produce
	task automatic push_tick(input logic [1:0] key, input logic typed = 1'b0,
			input ev_kind_t kind = EV_NONE, input logic [6:0] ch = CHAR_NONE);
		tick_result_t r;
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= {{(S_DATA_W-2){1'b0}}, 2'($urandom_range(3))};
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_DATA_W-2){1'b0}}, key};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		decode_tick(key, r);
		if (typed) begin
			r.kind = kind;
			r.ch   = ch;
		end
		pending.push_back(r);
		tick_count++;
	endtask

	// Register write, only once every result is out and the pipeline is empty
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_DOT_LIMIT:  cfg_dot_limit  = val;
			CFG_LETTER_GAP: cfg_letter_gap = val;
			CFG_WORD_GAP:   cfg_word_gap   = val;
			default: ;
		endcase
	endtask

	// Idle filler, now and then a key event the keyer should ignore
	function automatic logic [1:0] filler(input logic [1:0] stray);
		if ($urandom_range(9) == 0)
			return $urandom_range(1) ? stray : KEY_NOISE;
		return KEY_NONE;
	endfunction

	// One letter keyed with timings that fit the current registers
	task automatic send_letter();
		int dl, lg, wg;
		int n_el;
		int hold;
		int gap;
		int tail;
		dl = (cfg_dot_limit == 16'd0) ? 65536 : int'(cfg_dot_limit);
		lg = (cfg_letter_gap == 16'd0) ? 65536 : int'(cfg_letter_gap);
		wg = (cfg_word_gap == 16'd0) ? 65536 : int'(cfg_word_gap);
		// six elements run past the leaves
		n_el = ($urandom_range(9) < 8) ? $urandom_range(1, 5) : 6;
		for (int e = 0; e < n_el; e++) begin
			push_tick(KEY_PRESS);
			if ($urandom_range(1) == 0 || dl > 24)
				hold = $urandom_range(0, imin(dl - 1, 6));
			else
				hold = dl + $urandom_range(0, 2);
			repeat (hold) push_tick(filler(KEY_PRESS));
			push_tick(KEY_RELEASE);
			if (e < n_el - 1) begin
				gap = $urandom_range(0, imin(lg - 1, 5));
				repeat (gap) push_tick(filler(KEY_RELEASE));
			end
		end
		// end of letter, end of word, or a short pause that runs on
		case ($urandom_range(2))
			0:       tail = lg;
			1:       tail = wg;
			default: tail = $urandom_range(0, 10);
		endcase
		if (tail > 40)
			tail = $urandom_range(0, 10);
		else
			tail += $urandom_range(0, 2);
		repeat (tail) push_tick(filler(KEY_RELEASE));
	endtask

	task automatic run_phase(input int dl, input int lg, input int wg,
			input int src_pct, input int sink_pct, input int n_ticks);
		int start;
		cfg_write(CFG_DOT_LIMIT, 16'(dl));
		cfg_write(CFG_LETTER_GAP, 16'(lg));
		cfg_write(CFG_WORD_GAP, 16'(wg));
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		start = tick_count;
		while (tick_count - start < n_ticks) begin
			if ($urandom_range(99) < 85)
				send_letter();
			else
				repeat ($urandom_range(1, 8)) push_tick(2'($urandom_range(3)));
		end
	endtask

	// Receiver back-pressure
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Result checker, in order
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual tdata %h",
					$time, m_tdata);
				errors++;
			end else begin
				want = pending.pop_front();
				if (m_tdata[2:0] !== want.kind) begin
					$display("%0t: event_kind expected %0d actual %0d",
						$time, want.kind, m_tdata[2:0]);
					errors++;
				end
				if (m_tdata[9:3] !== want.ch) begin
					$display("%0t: character expected %h actual %h",
						$time, want.ch, m_tdata[9:3]);
					errors++;
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout, %0d results outstanding", $time, pending.size());
		$display("tb_top: errors");
		$finish;
	end

	initial begin
		int a_dot, a_let, a_word;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = CFG_DOT_LIMIT;
		cfg_data       = '0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		errors         = 0;
		tick_count     = 0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		reset_decoder_model();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		src_idle_pct   = 21;
		sink_stall_pct = 21;
		for (int i = 0; i < 27; i++) begin
			if (DIRECTED[i].op == ROW_CFG)
				cfg_write(DIRECTED[i].code, DIRECTED[i].val);
			else
				push_tick(DIRECTED[i].code, DIRECTED[i].typed, DIRECTED[i].kind,
					DIRECTED[i].ch);
		end

		a_dot  = $urandom_range(1, 6);
		a_let  = $urandom_range(2, 12);
		a_word = $urandom_range(a_let + 1, 30);
		run_phase(a_dot, a_let, a_word, 0, 0, 200);
		// shortest gaps: letters end on the tick after the release
		run_phase(1, 1, 2, 54, 0, 200);
		// long dot limit; word gap shorter than letter gap
		run_phase(65535, 5, 3, 0, 54, 200);
		// zero dot limit wraps to the full timer range
		run_phase(0, 4, 10, 21, 21, 200);
		// letters never time out, walks run into the leaves
		run_phase(2, 65535, 65535, 0, 0, 200);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

@@ sim.f @@
sv/mkd_pkg.sv
sv/mkd_keyer.sv
sv/mkd_walk.sv
sv/mkd_out_fifo.sv
sv/morse_key_decoder.sv
sv/mkd_checker.sv
tb/tb_top.sv
